[sv/tssl_pkg.sv]
// Package with payload types, register indexes and digit/segment tables for the display decoder.
`timescale 1ns / 1ps

package tssl_pkg;

  localparam int LEDS_PER_STRIP = 15;
  localparam int SEGS = 7;

  typedef struct packed {
    logic       time_valid;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
  } in_t;

  typedef struct packed {
    logic [LEDS_PER_STRIP-1:0] hour_leds;
    logic [LEDS_PER_STRIP-1:0] minute_leds;
    logic [7:0]                drive_brightness;
  } out_t;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_BLINK_DOTS        = 3'd0;
  localparam cfg_idx_t REG_USE_24H           = 3'd1;
  localparam cfg_idx_t REG_HIDE_LEADING_ZERO = 3'd2;
  localparam cfg_idx_t REG_AUTO_DIM          = 3'd3;
  localparam cfg_idx_t REG_DIM_START_HOUR    = 3'd4;
  localparam cfg_idx_t REG_DIM_END_HOUR      = 3'd5;
  localparam cfg_idx_t REG_BASE_BRIGHTNESS   = 3'd6;

  // Segment codes, bit 6 is segment a.
  localparam logic [SEGS-1:0] HOUR_SEG_TAB [10] = '{
    7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
  };
  localparam logic [SEGS-1:0] MIN_SEG_TAB [10] = '{
    7'h77, 7'h12, 7'h5D, 7'h5B, 7'h3A, 7'h6B, 7'h6F, 7'h52, 7'h7F, 7'h7B
  };
  // LED offset within a digit for segment i (i = 0 is segment a).
  localparam logic [2:0] HOUR_LED_POS [SEGS] = '{3'd1, 3'd0, 3'd4, 3'd5, 3'd6, 3'd2, 3'd3};
  localparam logic [2:0] MIN_LED_POS  [SEGS] = '{3'd5, 3'd4, 3'd6, 3'd3, 3'd0, 3'd2, 3'd1};

  // Tens digit of a value up to 63, by comparison against the decade bounds.
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60) begin
      t = 3'd6;
    end else if (v >= 6'd50) begin
      t = 3'd5;
    end else if (v >= 6'd40) begin
      t = 3'd4;
    end else if (v >= 6'd30) begin
      t = 3'd3;
    end else if (v >= 6'd20) begin
      t = 3'd2;
    end else if (v >= 6'd10) begin
      t = 3'd1;
    end else begin
      t = 3'd0;
    end
    return t;
  endfunction

  // Seven LEDs of one digit, ordered by the strip's LED wiring.
  function automatic logic [SEGS-1:0] digit_leds(input logic [3:0] d, input logic minute_strip);
    logic [SEGS-1:0] segs;
    logic [SEGS-1:0] leds;
    leds = '0;
    if (d <= 4'd9) begin
      segs = minute_strip ? MIN_SEG_TAB[d] : HOUR_SEG_TAB[d];
    end else begin
      segs = '0;
    end
    for (int i = 0; i < SEGS; i++) begin
      if (segs[SEGS-1-i]) begin
        if (minute_strip) begin
          leds[MIN_LED_POS[i]] = 1'b1;
        end else begin
          leds[HOUR_LED_POS[i]] = 1'b1;
        end
      end
    end
    return leds;
  endfunction

endpackage

[sv/time_to_seven_segment_leds_core.sv]
// Seven-segment clock display decoder: tick in, LED masks and brightness out.
`timescale 1ns / 1ps

// Usage:
//   in_valid/in_ready carry one display tick per transaction (time_valid, hour,
//   minute). Every accepted tick updates the dot state; a tick with time_valid
//   set produces one result transaction on out_valid/out_ready, a tick without
//   it produces none.
//   cfg_valid/cfg_ready write register cfg_index with cfg_data; cfg_ready is
//   always high. Indexes beyond the register list are ignored. Write registers
//   only while no result is pending.
//   The result is registered: a tick accepted at an edge shows its result from that edge.
//   Throughput is one tick per cycle while the receiver does not stall; the decode is a
//   single combinational pass from the input ports into the output register.
//   When the receiver stalls, the result is held and in_ready follows out_ready,
//   so a new tick is taken in the same cycle the held result leaves.
//   Reset restores the register defaults (blink on, 12-hour, dimming 22..6,
//   brightness 50), lights the dot and empties the output register.

module time_to_seven_segment_leds_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tssl_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tssl_pkg::out_t    out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  tssl_pkg::cfg_idx_t cfg_index,
  input  logic [7:0]        cfg_data
);

  logic       blink_dots_r;
  logic       use_24h_r;
  logic       hide_zero_r;
  logic       auto_dim_r;
  logic [4:0] dim_start_r;
  logic [4:0] dim_end_r;
  logic [7:0] base_bright_r;
  logic       dot_on_r;
  logic       dot_on_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  tssl_pkg::out_t out_data_r;
  tssl_pkg::out_t out_data_nxt;

  logic       in_fire;
  logic [4:0] hour;
  logic [2:0] h_tens;
  logic [3:0] h_units;
  logic [2:0] m_tens;
  logic [3:0] m_units;
  logic [5:0] h_tens_x10;
  logic [5:0] m_tens_x10;
  logic       show_h_tens;
  logic [15:0] third_prod;
  logic        dim_now;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    dot_on_nxt = blink_dots_r ? !dot_on_r : 1'b1;

    hour = in_data.hour_of_day;
    if (!use_24h_r) begin
      if (hour > 5'd12) begin
        hour = hour - 5'd12;
      end
      if (hour == 5'd0) begin
        hour = 5'd12;
      end
    end

    h_tens     = tssl_pkg::tens_of({1'b0, hour});
    h_tens_x10 = {h_tens, 3'b000} + {2'b00, h_tens, 1'b0};
    h_units    = 4'({1'b0, hour} - h_tens_x10);
    m_tens     = tssl_pkg::tens_of(in_data.minute_of_hour);
    m_tens_x10 = {m_tens, 3'b000} + {2'b00, m_tens, 1'b0};
    m_units    = 4'(in_data.minute_of_hour - m_tens_x10);

    show_h_tens = (h_tens != 3'd0) || (use_24h_r && !hide_zero_r);

    out_data_nxt.hour_leds = {7'b0, tssl_pkg::digit_leds(h_units, 1'b0), dot_on_nxt};
    if (show_h_tens) begin
      out_data_nxt.hour_leds[14:8] = tssl_pkg::digit_leds({1'b0, h_tens}, 1'b0);
    end
    out_data_nxt.minute_leds = {tssl_pkg::digit_leds(m_units, 1'b1),
                                tssl_pkg::digit_leds({1'b0, m_tens}, 1'b1),
                                dot_on_nxt};

    // Divide by three as x * 171 >> 9, exact for every 8-bit value.
    third_prod = {8'b0, base_bright_r} * 16'd171;
    dim_now    = auto_dim_r && ((in_data.hour_of_day >= dim_start_r) ||
                                (in_data.hour_of_day < dim_end_r));
    out_data_nxt.drive_brightness = dim_now ? {1'b0, third_prod[15:9]} : base_bright_r;

    if (in_fire) begin
      out_valid_nxt = in_data.time_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_dots_r  <= 1'b1;
      use_24h_r     <= 1'b0;
      hide_zero_r   <= 1'b0;
      auto_dim_r    <= 1'b1;
      dim_start_r   <= 5'd22;
      dim_end_r     <= 5'd6;
      base_bright_r <= 8'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tssl_pkg::REG_BLINK_DOTS:        blink_dots_r  <= cfg_data[0];
        tssl_pkg::REG_USE_24H:           use_24h_r     <= cfg_data[0];
        tssl_pkg::REG_HIDE_LEADING_ZERO: hide_zero_r   <= cfg_data[0];
        tssl_pkg::REG_AUTO_DIM:          auto_dim_r    <= cfg_data[0];
        tssl_pkg::REG_DIM_START_HOUR:    dim_start_r   <= cfg_data[4:0];
        tssl_pkg::REG_DIM_END_HOUR:      dim_end_r     <= cfg_data[4:0];
        tssl_pkg::REG_BASE_BRIGHTNESS:   base_bright_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_on_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        dot_on_r <= dot_on_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.time_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  // With blinking off, every tick leaves the dot lit.
  a_dot_forced: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !blink_dots_r) |=> dot_on_r)
    else $error("dot not lit after tick with blinking off");

  // A valid-time tick always produces a pending result.
  a_valid_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.time_valid) |=> out_valid_r)
    else $error("valid tick produced no result");

  // An invalid-time tick taken while the old result drains leaves nothing pending.
  a_invalid_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_data.time_valid) |=> !out_valid_r)
    else $error("invalid tick produced a result");

  // Both strips show the same dot state.
  a_dot_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.hour_leds[0] == out_data_r.minute_leds[0]))
    else $error("dot differs between strips");

  // The dot shown in a fresh result is the dot state just stored.
  a_dot_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.time_valid) |=> (out_data_r.hour_leds[0] == dot_on_r))
    else $error("result dot does not match dot state");

endmodule
